// ===== src/lqc_pkg.sv =====
// shared types, constants and codes for the link quality classifier
`timescale 1ns / 1ps
package lqc_pkg;

	localparam int WINDOW_BITS = 10;
	localparam int SLOT_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
	localparam int CNT_W = $clog2(WINDOW_BITS + 1);
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LIMIT_W = 16;

	typedef enum logic [1:0] {
		ST_EVAL      = 2'd0,
		ST_EXCELLENT = 2'd1,
		ST_BAD       = 2'd2
	} lqc_state_t;

	typedef enum logic [2:0] {
		CLS_FAILED = 3'd0,
		CLS_NORMAL = 3'd1,
		CLS_SMALL  = 3'd2,
		CLS_MIDDLE = 3'd3,
		CLS_BIG    = 3'd4,
		CLS_BIGGER = 3'd5
	} lqc_class_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SMALL_PKG   = 3'd0,
		REG_MIDDLE_PKG  = 3'd1,
		REG_BIG_PKG     = 3'd2,
		REG_WIFI_LIM    = 3'd3,
		REG_MOBILE_LIM  = 3'd4,
		REG_EXPIRE      = 3'd5,
		REG_GOOD_RUN    = 3'd6,
		REG_MIN_NORMAL  = 3'd7
	} lqc_reg_t;

	typedef struct packed {
		logic [31:0] small_pkg_bytes;
		logic [31:0] middle_pkg_bytes;
		logic [31:0] big_pkg_bytes;
		logic [63:0] wifi_cost_limits;
		logic [63:0] mobile_cost_limits;
		logic [31:0] expire_ticks;
		logic [15:0] good_run_needed;
		logic [5:0]  min_normal_count;
	} lqc_cfg_t;

	typedef struct packed {
		logic [1:0] link_status;
		logic [2:0] task_class;
		logic [6:0] normal_in_window;
	} lqc_result_t;

endpackage

// ===== src/lqc_in_if.sv =====
// transfer report channel
`timescale 1ns / 1ps
interface lqc_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] total_size;
	logic [31:0] cost_ms;
	logic        task_failed;
	logic        on_mobile;
	logic [31:0] now_ticks;

	modport source (
		output valid, action, total_size, cost_ms, task_failed, on_mobile, now_ticks,
		input  ready
	);
	modport sink (
		input  valid, action, total_size, cost_ms, task_failed, on_mobile, now_ticks,
		output ready
	);
endinterface

// ===== src/lqc_out_if.sv =====
// link status result channel
`timescale 1ns / 1ps
interface lqc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] link_status;
	logic [2:0] task_class;
	logic [6:0] normal_in_window;

	modport source (
		output valid, link_status, task_class, normal_in_window,
		input  ready
	);
	modport sink (
		input  valid, link_status, task_class, normal_in_window,
		output ready
	);
endinterface

// ===== src/link_quality_classifier_unit.sv =====
// link quality classifier top level: config registers, input stage and result register
//
//   channel  modport  direction  contents
//   req      sink     in         action, total_size, cost_ms, task_failed, on_mobile, now_ticks
//   rsp      source   out        link_status, task_class, normal_in_window
//   cfg_*    plain    in         write enable, register index, 64-bit data
//
// one word per cycle sustained while rsp stays ready; each word is registered in the input stage
// (classify) and then in the result register (status update) before it is on rsp
// the status update reads the state registers combinationally and writes them back when the word fires
// arst_n clears status and both valid flags and loads the config registers with their defaults
// a stalled rsp holds its word; req stays ready while the input stage can drain
`timescale 1ns / 1ps
module link_quality_classifier_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lqc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lqc_pkg::CFG_DATA_W-1:0]     cfg_data,
	lqc_in_if.sink                             req,
	lqc_out_if.source                          rsp
);
	import lqc_pkg::*;

	lqc_cfg_t    cfg_q;
	lqc_class_t  cls;
	lqc_class_t  cls_s1;
	logic        valid_s1;
	logic        action_s1;
	logic [31:0] now_s1;
	logic        fire;
	logic        out_valid_q;
	lqc_result_t result;
	lqc_result_t result_q;

	assign fire      = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.small_pkg_bytes    <= 32'd10240;
			cfg_q.middle_pkg_bytes   <= 32'd30720;
			cfg_q.big_pkg_bytes      <= 32'd102400;
			cfg_q.wifi_cost_limits   <= '0;
			cfg_q.mobile_cost_limits <= '0;
			cfg_q.expire_ticks       <= 32'd180000;
			cfg_q.good_run_needed    <= 16'd10;
			cfg_q.min_normal_count   <= 6'd3;
		end else if (cfg_we) begin
			unique case (lqc_reg_t'(cfg_index))
				REG_SMALL_PKG:  cfg_q.small_pkg_bytes    <= cfg_data[31:0];
				REG_MIDDLE_PKG: cfg_q.middle_pkg_bytes   <= cfg_data[31:0];
				REG_BIG_PKG:    cfg_q.big_pkg_bytes      <= cfg_data[31:0];
				REG_WIFI_LIM:   cfg_q.wifi_cost_limits   <= cfg_data;
				REG_MOBILE_LIM: cfg_q.mobile_cost_limits <= cfg_data;
				REG_EXPIRE:     cfg_q.expire_ticks       <= cfg_data[31:0];
				REG_GOOD_RUN:   cfg_q.good_run_needed    <= cfg_data[15:0];
				REG_MIN_NORMAL: cfg_q.min_normal_count   <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	lqc_classify u_classify (
		.total_size  (req.total_size),
		.cost_ms     (req.cost_ms),
		.task_failed (req.task_failed),
		.on_mobile   (req.on_mobile),
		.cfg         (cfg_q),
		.cls         (cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			cls_s1    <= req.action ? CLS_FAILED : cls;
			now_s1    <= req.now_ticks;
		end
	end

	lqc_status u_status (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.action    (action_s1),
		.cls       (cls_s1),
		.now_ticks (now_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.link_status      = result_q.link_status;
	assign rsp.task_class       = result_q.task_class;
	assign rsp.normal_in_window = result_q.normal_in_window;

endmodule

// ===== src/lqc_classify.sv =====
// transfer classification by size band and per-link cost limit
`timescale 1ns / 1ps
module lqc_classify (
	input  logic [31:0]       total_size,
	input  logic [31:0]       cost_ms,
	input  logic              task_failed,
	input  logic              on_mobile,
	input  lqc_pkg::lqc_cfg_t cfg,
	output lqc_pkg::lqc_class_t cls
);
	import lqc_pkg::*;

	logic [63:0]        limits;
	logic [LIMIT_W-1:0] limit;
	lqc_class_t         met_cls;

	assign limits = on_mobile ? cfg.mobile_cost_limits : cfg.wifi_cost_limits;

	always_comb begin
		priority if (total_size < cfg.small_pkg_bytes) begin
			met_cls = CLS_SMALL;
			limit   = limits[15:0];
		end else if (total_size <= cfg.middle_pkg_bytes) begin
			met_cls = CLS_MIDDLE;
			limit   = limits[31:16];
		end else if (total_size <= cfg.big_pkg_bytes) begin
			met_cls = CLS_BIG;
			limit   = limits[47:32];
		end else begin
			met_cls = CLS_BIGGER;
			limit   = limits[63:48];
		end
	end

	always_comb begin
		priority if (task_failed || cost_ms == 32'd0) begin
			cls = CLS_FAILED;
		end else if (cost_ms <= {16'd0, limit}) begin
			cls = met_cls;
		end else begin
			cls = CLS_NORMAL;
		end
	end

endmodule

// ===== src/lqc_status.sv =====
// run counter, outcome window and link state machine
`timescale 1ns / 1ps
module lqc_status (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 action,
	input  lqc_pkg::lqc_class_t  cls,
	input  logic [31:0]          now_ticks,
	input  lqc_pkg::lqc_cfg_t    cfg,
	output lqc_pkg::lqc_result_t result
);
	import lqc_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_BITS - 1);
	localparam logic [WINDOW_BITS-1:0] WIN_ONES = '1;

	lqc_state_t             state_q, state_d;
	logic [15:0]            run_q, run_d;
	logic [31:0]            tick_q, tick_d;
	logic [WINDOW_BITS-1:0] win_q, win_d, win_r;
	logic [31:0]            stamp_q, stamp_d;
	logic [SLOT_W-1:0]      slot_q, slot_d, slot_r;
	logic [CNT_W-1:0]       cnt;
	logic                   restart;
	logic                   good;
	logic                   eval;
	logic                   cnt_low;

	assign eval    = (state_q == ST_EVAL);
	assign good    = (cls != CLS_FAILED) && (cls != CLS_NORMAL);
	assign restart = (stamp_q == 32'd0) || ((now_ticks - stamp_q) > cfg.expire_ticks);
	assign win_r   = restart ? ((state_q == ST_BAD) ? '0 : WIN_ONES) : win_q;
	assign slot_r  = restart ? LAST_SLOT : slot_q;

	always_comb begin
		slot_d = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
		run_d  = run_q;
		tick_d = tick_q;
		win_d  = win_r;
		if (good) begin
			if (eval) begin
				if (cls != CLS_SMALL) begin
					tick_d = now_ticks;
				end
				if (run_q != 16'hFFFF) begin
					run_d = run_q + 16'd1;
				end
			end
			win_d[slot_d] = 1'b1;
		end else if (cls == CLS_NORMAL) begin
			if (eval) begin
				run_d  = '0;
				tick_d = '0;
			end
			win_d[slot_d] = 1'b1;
		end else begin
			run_d         = '0;
			tick_d        = '0;
			win_d[slot_d] = 1'b0;
		end
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < WINDOW_BITS; i++) begin
			cnt = cnt + CNT_W'(win_d[i]);
		end
	end

	assign cnt_low = ({{(7-CNT_W){1'b0}}, cnt} <= {1'b0, cfg.min_normal_count});

	always_comb begin
		state_d = state_q;
		stamp_d = restart ? now_ticks : stamp_q;
		unique case (state_q)
			ST_EVAL: begin
				if (run_d >= cfg.good_run_needed && (now_ticks - tick_d) <= cfg.expire_ticks) begin
					state_d = ST_EXCELLENT;
				end else if (cnt_low) begin
					state_d = ST_BAD;
					stamp_d = '0;
				end
			end
			ST_EXCELLENT: begin
				if (run_d == 16'd0 && tick_d == 32'd0) begin
					state_d = ST_EVAL;
				end
			end
			ST_BAD: begin
				if (!cnt_low) begin
					state_d = ST_EVAL;
					stamp_d = '0;
				end
			end
			default: begin
				state_d = ST_EVAL;
			end
		endcase
	end

	always_comb begin
		if (action) begin
			result.link_status      = ST_EVAL;
			result.task_class       = CLS_FAILED;
			result.normal_in_window = 7'(WINDOW_BITS);
		end else begin
			result.link_status      = state_d;
			result.task_class       = cls;
			result.normal_in_window = {{(7-CNT_W){1'b0}}, cnt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EVAL;
			run_q   <= '0;
			tick_q  <= '0;
			win_q   <= WIN_ONES;
			stamp_q <= '0;
			slot_q  <= LAST_SLOT;
		end else if (fire) begin
			if (action) begin
				state_q <= ST_EVAL;
				run_q   <= '0;
				tick_q  <= '0;
				win_q   <= WIN_ONES;
				stamp_q <= '0;
				slot_q  <= LAST_SLOT;
			end else begin
				state_q <= state_d;
				run_q   <= run_d;
				tick_q  <= tick_d;
				win_q   <= win_d;
				stamp_q <= stamp_d;
				slot_q  <= slot_d;
			end
		end
	end

	a_reset_action: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action |=> state_q == ST_EVAL && run_q == 16'd0 && win_q == WIN_ONES)
		else $error("reset action did not clear status");

	a_failed_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !action && cls == CLS_FAILED |=> run_q == 16'd0 && tick_q == 32'd0)
		else $error("failed word left run or good tick set");

	a_bad_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !action && state_d != state_q && (state_d == ST_BAD || state_q == ST_BAD)
		|=> stamp_q == 32'd0)
		else $error("stamp not cleared on bad entry or exit");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("window slot out of range");

	a_no_bad_to_excellent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BAD |=> state_q != ST_EXCELLENT)
		else $error("bad moved straight to excellent");

endmodule

// ===== tb/tb.sv =====
// self-checking bench for link_quality_classifier_unit with a built-in status predictor
`timescale 1ns / 1ps
module tb;
	import lqc_pkg::*;

	localparam int STUCK_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic        action;
		logic [31:0] total_size;
		logic [31:0] cost_ms;
		logic        task_failed;
		logic        on_mobile;
		logic [31:0] now_ticks;
	} transfer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lqc_in_if req_if ();
	lqc_out_if rsp_if ();

	link_quality_classifier_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	transfer_t pending_transfers[$];
	lqc_result_t expected_status[$];

	// predictor copy of registers and link state
	lqc_cfg_t shadow_cfg;
	lqc_state_t link_st;
	logic [15:0] good_run;
	logic [31:0] last_good_tick;
	logic [WINDOW_BITS-1:0] outcome_bits;
	logic [31:0] window_stamp;
	int unsigned window_slot;

	logic [31:0] tick_now;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_req_id;
	int unsigned hold_req_len;
	int unsigned hold_seen_id = 0;
	int unsigned hold_left = 0;
	int unsigned mismatches;
	int unsigned stuck_cycles = 0;

	function automatic void clear_status();
		link_st = ST_EVAL;
		good_run = '0;
		last_good_tick = '0;
		outcome_bits = '1;
		window_stamp = '0;
		window_slot = WINDOW_BITS - 1;
	endfunction

	function automatic lqc_class_t classify_transfer(transfer_t t);
		logic [63:0] lim;
		logic [15:0] cap;
		lqc_class_t cls;
		lim = t.on_mobile ? shadow_cfg.mobile_cost_limits : shadow_cfg.wifi_cost_limits;
		if (t.task_failed || t.cost_ms == 32'd0)
			return CLS_FAILED;
		if (t.total_size < shadow_cfg.small_pkg_bytes) begin
			cls = CLS_SMALL;
			cap = lim[15:0];
		end else if (t.total_size <= shadow_cfg.middle_pkg_bytes) begin
			cls = CLS_MIDDLE;
			cap = lim[31:16];
		end else if (t.total_size <= shadow_cfg.big_pkg_bytes) begin
			cls = CLS_BIG;
			cap = lim[47:32];
		end else begin
			cls = CLS_BIGGER;
			cap = lim[63:48];
		end
		return (t.cost_ms <= {16'd0, cap}) ? cls : CLS_NORMAL;
	endfunction

	function automatic lqc_result_t grade_transfer(transfer_t t);
		lqc_result_t r;
		lqc_class_t cls;
		logic was_eval;
		logic [31:0] age;
		int unsigned cnt;
		cls = CLS_FAILED;
		if (t.action) begin
			clear_status();
		end else begin
			was_eval = (link_st == ST_EVAL);
			cls = classify_transfer(t);
			age = t.now_ticks - window_stamp;
			if (window_stamp == 32'd0 || age > shadow_cfg.expire_ticks) begin
				window_stamp = t.now_ticks;
				window_slot = WINDOW_BITS - 1;
				outcome_bits = (link_st == ST_BAD) ? '0 : '1;
			end
			window_slot = (window_slot + 1 >= WINDOW_BITS) ? 0 : window_slot + 1;
			if (cls >= CLS_SMALL) begin
				if (was_eval) begin
					if (cls >= CLS_MIDDLE)
						last_good_tick = t.now_ticks;
					if (good_run != 16'hFFFF)
						good_run = good_run + 16'd1;
				end
				outcome_bits[window_slot] = 1'b1;
			end else if (cls == CLS_NORMAL) begin
				if (was_eval) begin
					good_run = '0;
					last_good_tick = '0;
				end
				outcome_bits[window_slot] = 1'b1;
			end else begin
				good_run = '0;
				last_good_tick = '0;
				outcome_bits[window_slot] = 1'b0;
			end
			cnt = $countones(outcome_bits);
			age = t.now_ticks - last_good_tick;
			case (link_st)
				ST_EVAL: begin
					if (good_run >= shadow_cfg.good_run_needed &&
					    age <= shadow_cfg.expire_ticks) begin
						link_st = ST_EXCELLENT;
					end else if (cnt <= shadow_cfg.min_normal_count) begin
						link_st = ST_BAD;
						window_stamp = '0;
					end
				end
				ST_EXCELLENT: begin
					if (good_run == 16'd0 && last_good_tick == 32'd0)
						link_st = ST_EVAL;
				end
				default: begin
					if (cnt > shadow_cfg.min_normal_count) begin
						link_st = ST_EVAL;
						window_stamp = '0;
					end
				end
			endcase
		end
		r.link_status = link_st;
		r.task_class = cls;
		r.normal_in_window = 7'($countones(outcome_bits));
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic void add_transfer(logic act, logic [31:0] size, logic [31:0] cost,
	                                     logic failed, logic mobile, logic [31:0] now);
		transfer_t t;
		t.action = act;
		t.total_size = size;
		t.cost_ms = cost;
		t.task_failed = failed;
		t.on_mobile = mobile;
		t.now_ticks = now;
		pending_transfers.push_back(t);
	endfunction

	function automatic logic [31:0] next_tick();
		case ($urandom_range(0, 39))
			0: tick_now = $urandom;
			1: tick_now = tick_now + shadow_cfg.expire_ticks + $urandom_range(1, 50);
			2: return 32'd0;
			3: tick_now = tick_now + shadow_cfg.expire_ticks;
			default: tick_now = tick_now + $urandom_range(0, 3000);
		endcase
		return tick_now;
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return shadow_cfg.small_pkg_bytes - 32'd1;
			2: return shadow_cfg.small_pkg_bytes;
			3: return shadow_cfg.middle_pkg_bytes;
			4: return shadow_cfg.middle_pkg_bytes + 32'd1;
			5: return shadow_cfg.big_pkg_bytes;
			6: return shadow_cfg.big_pkg_bytes + 32'd1;
			7: return 32'd0;
			8: return 32'hFFFF_FFFF;
			default: return $urandom_range(0, shadow_cfg.big_pkg_bytes + 32'd20000);
		endcase
	endfunction

	function automatic logic [31:0] pick_cost(logic keen);
		if (keen)
			return $urandom_range(1, 450);
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'd65536;
			3: return 32'd65535;
			default: return $urandom_range(1, 9000);
		endcase
	endfunction

	// streaks of good, failed or over-limit words, with noise and status resets between
	function automatic void queue_random(int unsigned n);
		int unsigned made;
		int unsigned len;
		int unsigned kind;
		logic mob;
		logic fail_flag;
		made = 0;
		while (made < n) begin
			len = $urandom_range(3, 16);
			kind = $urandom_range(0, 9);
			mob = 1'($urandom_range(0, 1));
			repeat (len) begin
				fail_flag = 1'($urandom_range(0, 1));
				case (kind)
					0, 1, 2, 3: add_transfer(1'b0, pick_size(), pick_cost(1'b1), 1'b0, mob,
					                         next_tick());
					4, 5: add_transfer(1'b0, pick_size(), fail_flag ? pick_cost(1'b0) : 32'd0,
					                   fail_flag, mob, next_tick());
					6: add_transfer(1'b0, pick_size(), $urandom_range(9000, 65535), 1'b0, mob,
					                next_tick());
					default: add_transfer($urandom_range(0, 49) == 0, pick_size(), pick_cost(1'b0),
					                      $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)),
					                      next_tick());
				endcase
			end
			made += len;
			if ($urandom_range(0, 19) == 0) begin
				add_transfer(1'b1, $urandom, $urandom, 1'($urandom_range(0, 1)),
				             1'($urandom_range(0, 1)), $urandom);
				made++;
			end
		end
	endfunction

	// assumes wifi limits 500/1000/2000/4000, mobile twice that, default bands and expiry
	function automatic void queue_directed();
		add_transfer(1'b0, 32'd0, 32'd500, 1'b0, 1'b0, 32'd100);
		add_transfer(1'b0, 32'd10239, 32'd501, 1'b0, 1'b0, 32'd200);
		add_transfer(1'b0, 32'd10240, 32'd1000, 1'b0, 1'b0, 32'd300);
		add_transfer(1'b0, 32'd30720, 32'd2000, 1'b0, 1'b1, 32'd400);
		add_transfer(1'b0, 32'd30721, 32'd2000, 1'b0, 1'b0, 32'd500);
		add_transfer(1'b0, 32'd102400, 32'd4001, 1'b0, 1'b1, 32'd600);
		add_transfer(1'b0, 32'd102401, 32'd4000, 1'b0, 1'b0, 32'd700);
		add_transfer(1'b0, 32'hFFFF_FFFF, 32'd8000, 1'b0, 1'b1, 32'd800);
		add_transfer(1'b0, 32'd5000, 32'd0, 1'b0, 1'b0, 32'd900);
		add_transfer(1'b0, 32'd5000, 32'd100, 1'b1, 1'b0, 32'd1000);
		add_transfer(1'b0, 32'd5000, 32'd65536, 1'b0, 1'b1, 32'd1100);
		add_transfer(1'b0, 32'd5000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd1200);
		// zero tick leaves the window stamp unset
		add_transfer(1'b0, 32'd5000, 32'd100, 1'b0, 1'b0, 32'd0);
		add_transfer(1'b0, 32'd5000, 32'd100, 1'b0, 1'b0, 32'd1300);
		add_transfer(1'b0, 32'd5000, 32'd100, 1'b0, 1'b0, 32'd181301);
		add_transfer(1'b0, 32'd5000, 32'd100, 1'b0, 1'b0, 32'hFFFF_FFF0);
		add_transfer(1'b0, 32'd5000, 32'd100, 1'b0, 1'b0, 32'd10);
		add_transfer(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		// failures pull the window down until the link goes bad
		for (int i = 0; i < 7; i++)
			add_transfer(1'b0, 32'd20000, 32'd0, 1'b1, 1'b0, 32'd2000 + 32'(i) * 32'd10);
		tick_now = 32'd3000;
	endfunction

	task automatic write_reg(lqc_reg_t idx, logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic load_config(lqc_cfg_t c);
		write_reg(REG_SMALL_PKG, {32'd0, c.small_pkg_bytes});
		write_reg(REG_MIDDLE_PKG, {32'd0, c.middle_pkg_bytes});
		write_reg(REG_BIG_PKG, {32'd0, c.big_pkg_bytes});
		write_reg(REG_WIFI_LIM, c.wifi_cost_limits);
		write_reg(REG_MOBILE_LIM, c.mobile_cost_limits);
		write_reg(REG_EXPIRE, {32'd0, c.expire_ticks});
		write_reg(REG_GOOD_RUN, {48'd0, c.good_run_needed});
		write_reg(REG_MIN_NORMAL, {58'd0, c.min_normal_count});
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cfg = c;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_transfers.size() != 0 || req_if.valid || expected_status.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (pending_transfers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				{req_if.action, req_if.total_size, req_if.cost_ms, req_if.task_failed,
				 req_if.on_mobile, req_if.now_ticks} <= pending_transfers.pop_front();
				req_if.valid <= 1'b1;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_seen_id <= 0;
			hold_left <= 0;
		end else if (hold_seen_id != hold_req_id) begin
			hold_seen_id <= hold_req_id;
			hold_left <= hold_req_len;
			rsp_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		transfer_t seen;
		lqc_result_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_status.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_status.pop_front();
					if (rsp_if.link_status !== want.link_status)
						report_mismatch($sformatf("link_status %0d, expected %0d",
						                          rsp_if.link_status, want.link_status));
					if (rsp_if.task_class !== want.task_class)
						report_mismatch($sformatf("task_class %0d, expected %0d",
						                          rsp_if.task_class, want.task_class));
					if (rsp_if.normal_in_window !== want.normal_in_window)
						report_mismatch($sformatf("normal_in_window %0d, expected %0d",
						                          rsp_if.normal_in_window,
						                          want.normal_in_window));
				end
			end
			if (req_if.valid && req_if.ready) begin
				seen = {req_if.action, req_if.total_size, req_if.cost_ms, req_if.task_failed,
				        req_if.on_mobile, req_if.now_ticks};
				expected_status.push_back(grade_transfer(seen));
			end
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		lqc_cfg_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SMALL_PKG;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req_id = 0;
		hold_req_len = 0;
		mismatches = 0;
		tick_now = $urandom_range(1, 1000);
		shadow_cfg = '{32'd10240, 32'd30720, 32'd102400, 64'd0, 64'd0, 32'd180000,
		               16'd10, 6'd3};
		clear_status();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// values out of reset: no limits, so nothing meets
		queue_random(80);
		wait_drained();

		c = shadow_cfg;
		c.wifi_cost_limits = {16'd4000, 16'd2000, 16'd1000, 16'd500};
		c.mobile_cost_limits = {16'd8000, 16'd4000, 16'd2000, 16'd1000};
		load_config(c);
		queue_directed();
		queue_random(150);
		wait_drained();

		send_idle_pct = 52;
		c.expire_ticks = 32'd5000;
		c.good_run_needed = 16'd4;
		load_config(c);
		queue_random(150);
		wait_drained();

		// receiver holds off long enough to back up the input
		send_idle_pct = 0;
		recv_stall_pct = 52;
		c.small_pkg_bytes = 32'd1000;
		c.middle_pkg_bytes = 32'd5000;
		c.big_pkg_bytes = 32'd20000;
		c.expire_ticks = 32'd60000;
		c.min_normal_count = 6'd5;
		load_config(c);
		hold_req_len = LONG_HOLD;
		hold_req_id++;
		queue_random(150);
		wait_drained();

		// low extremes
		send_idle_pct = 38;
		recv_stall_pct = 38;
		c = '{32'd0, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0,
		      16'd0, 6'd0};
		load_config(c);
		queue_random(150);
		wait_drained();

		// high extremes
		send_idle_pct = 0;
		recv_stall_pct = 0;
		c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 64'd0, 32'hFFFF_FFFF,
		      16'hFFFF, 6'h3F};
		load_config(c);
		queue_random(100);
		wait_drained();

		send_idle_pct = 52;
		recv_stall_pct = 52;
		c.small_pkg_bytes = $urandom_range(0, 50000);
		c.middle_pkg_bytes = c.small_pkg_bytes + $urandom_range(0, 50000);
		c.big_pkg_bytes = c.middle_pkg_bytes + $urandom_range(0, 100000);
		c.wifi_cost_limits = {$urandom, $urandom};
		c.mobile_cost_limits = {$urandom, $urandom};
		c.expire_ticks = $urandom_range(1000, 500000);
		c.good_run_needed = 16'($urandom_range(1, 20));
		c.min_normal_count = 6'($urandom_range(0, 9));
		load_config(c);
		queue_random(200);
		wait_drained();

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== link_quality_classifier_unit.f =====
src/lqc_pkg.sv
src/lqc_in_if.sv
src/lqc_out_if.sv
src/lqc_classify.sv
src/lqc_status.sv
src/link_quality_classifier_unit.sv
tb/tb.sv
